// ===== hw/rtl/tcent_pkg.sv =====
`timescale 1ns / 1ps

package tcent_pkg;

    // Field and register widths
    localparam int CHAN_W     = 8;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int CENT_W     = 10;
    localparam int COUNT_W    = 21;
    localparam int SUM_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd1;

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;
    localparam logic [FW_W-1:0]  FW_RESET  = 11'd640;

    // Saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // Frame queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Divider: one quotient bit per cycle over the whole dividend
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = 5;
    localparam int REM_W     = COUNT_W + 1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              end_of_frame;
    } t_pixel;

    typedef struct packed {
        logic [CENT_W-1:0]  centroid_x;
        logic [CENT_W-1:0]  centroid_y;
        logic [COUNT_W-1:0] foreground_count;
        logic               found;
    } t_result;

    // Totals of one finished frame
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
    } t_frame_sum;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hw/rtl/tcent_front.sv =====
`timescale 1ns / 1ps

module tcent_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tcent_pkg::t_pixel                   i_in_data,
    input  logic                                i_cfg_we,
    input  logic [tcent_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcent_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tcent_pkg::t_q_status                i_q_status,
    output logic                                o_push,
    output tcent_pkg::t_frame_sum               o_push_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMP_W = (CW + 1 > 12) ? CW + 1 : 12;
    localparam logic [CMP_W-1:0] WIDTH_LIM  = CMP_W'(MAX_WIDTH);
    localparam logic [RW:0]      HEIGHT_LIM = (RW + 1)'(MAX_HEIGHT);

    logic [tcent_pkg::THR_W-1:0]   r_thr;
    logic [tcent_pkg::FW_W-1:0]    r_fw;
    logic [CW-1:0]                 r_col, n_col;
    logic [RW-1:0]                 r_row, n_row;
    logic [tcent_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [tcent_pkg::SUM_W-1:0]   r_csum, n_csum;
    logic [tcent_pkg::SUM_W-1:0]   r_rsum, n_rsum;

    logic                          accept;
    logic [9:0]                    chan_sum;
    logic [9:0]                    thr_lim;
    logic                          hit;
    logic [CMP_W-1:0]              eff_width;
    logic [CMP_W-1:0]              fw_ext;
    logic [CW:0]                   col_inc;
    logic [RW:0]                   row_inc;
    logic [tcent_pkg::SUM_W:0]     csum_add;
    logic [tcent_pkg::SUM_W:0]     rsum_add;
    logic [tcent_pkg::COUNT_W-1:0] hit_cnt;
    logic [tcent_pkg::SUM_W-1:0]   hit_csum;
    logic [tcent_pkg::SUM_W-1:0]   hit_rsum;

    // Stall while the queue cannot take a frame
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    // Mean above threshold: sum > 3 * thr + 2
    assign chan_sum = 10'(i_in_data.red) + 10'(i_in_data.green) + 10'(i_in_data.blue);
    assign thr_lim  = {1'b0, r_thr, 1'b0} + 10'(r_thr) + 10'd2;
    assign hit      = (chan_sum > thr_lim) && (r_cnt != tcent_pkg::COUNT_MAX);

    // Clamp the configured width into one to max
    assign fw_ext = CMP_W'(r_fw);
    always_comb begin
        if (r_fw == '0) begin
            eff_width = CMP_W'(1);
        end else if (fw_ext > WIDTH_LIM) begin
            eff_width = WIDTH_LIM;
        end else begin
            eff_width = fw_ext;
        end
    end

    assign col_inc = (CW + 1)'(r_col) + (CW + 1)'(1);
    assign row_inc = (RW + 1)'(r_row) + (RW + 1)'(1);

    // Saturating sums of position plus one
    assign csum_add = (tcent_pkg::SUM_W + 1)'(r_csum) + (tcent_pkg::SUM_W + 1)'(col_inc);
    assign rsum_add = (tcent_pkg::SUM_W + 1)'(r_rsum) + (tcent_pkg::SUM_W + 1)'(row_inc);

    always_comb begin
        hit_cnt  = r_cnt;
        hit_csum = r_csum;
        hit_rsum = r_rsum;
        if (hit) begin
            hit_cnt  = r_cnt + tcent_pkg::COUNT_W'(1);
            hit_csum = csum_add[tcent_pkg::SUM_W] ? tcent_pkg::SUM_MAX
                                                  : csum_add[tcent_pkg::SUM_W-1:0];
            hit_rsum = rsum_add[tcent_pkg::SUM_W] ? tcent_pkg::SUM_MAX
                                                  : rsum_add[tcent_pkg::SUM_W-1:0];
        end
    end

    // Advance position and accumulators; clear after the frame's last word
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cnt  = r_cnt;
        n_csum = r_csum;
        n_rsum = r_rsum;
        if (accept) begin
            if (i_in_data.end_of_frame) begin
                n_col  = '0;
                n_row  = '0;
                n_cnt  = '0;
                n_csum = '0;
                n_rsum = '0;
            end else begin
                n_cnt  = hit_cnt;
                n_csum = hit_csum;
                n_rsum = hit_rsum;
                if (CMP_W'(col_inc) >= eff_width) begin
                    n_col = '0;
                    if (row_inc < HEIGHT_LIM) begin
                        n_row = row_inc[RW-1:0];
                    end
                end else begin
                    n_col = col_inc[CW-1:0];
                end
            end
        end
    end

    // Hand the finished frame to the queue
    assign o_push              = accept && i_in_data.end_of_frame;
    assign o_push_data.count   = hit_cnt;
    assign o_push_data.col_sum = hit_csum;
    assign o_push_data.row_sum = hit_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= tcent_pkg::THR_RESET;
            r_fw   <= tcent_pkg::FW_RESET;
            r_col  <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
            r_csum <= '0;
            r_rsum <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == tcent_pkg::REG_THRESHOLD) begin
                r_thr <= i_cfg_data[tcent_pkg::THR_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == tcent_pkg::REG_FRAME_WIDTH) begin
                r_fw <= i_cfg_data[tcent_pkg::FW_W-1:0];
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_cnt  <= n_cnt;
            r_csum <= n_csum;
            r_rsum <= n_rsum;
        end
    end

endmodule

// ===== hw/rtl/tcent_queue.sv =====
`timescale 1ns / 1ps

module tcent_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tcent_pkg::t_frame_sum i_push_data,
    input  logic                  i_pop,
    output tcent_pkg::t_frame_sum o_pop_data,
    output tcent_pkg::t_q_status  o_status
);

    tcent_pkg::t_frame_sum           r_entry [tcent_pkg::QUEUE_DEPTH];
    logic [tcent_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [tcent_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [tcent_pkg::QCNT_W-1:0]    r_fill;
    logic                            do_push;
    logic                            do_pop;

    assign o_status.full  = (r_fill == tcent_pkg::QCNT_W'(tcent_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_data     = r_entry[r_rd_ptr];

    // Store frame totals
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + tcent_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + tcent_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + tcent_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - tcent_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/tcent_back.sv =====
`timescale 1ns / 1ps

module tcent_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcent_pkg::t_q_status  i_q_status,
    input  tcent_pkg::t_frame_sum i_pop_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcent_pkg::t_result    o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [tcent_pkg::COUNT_W-1:0]     r_cnt;
    logic [tcent_pkg::SUM_W-1:0]       r_dvd_x, r_dvd_y;
    logic [tcent_pkg::COUNT_W-1:0]     r_rem_x, r_rem_y;
    logic [tcent_pkg::CENT_W-1:0]      r_q_x, r_q_y;
    logic [tcent_pkg::STEP_W-1:0]      r_step;
    logic                              r_out_valid;
    tcent_pkg::t_result                r_out;

    logic [tcent_pkg::REM_W-1:0]       sh_x, sh_y;
    logic [tcent_pkg::REM_W-1:0]       dvs;
    logic                              ge_x, ge_y;
    logic [tcent_pkg::REM_W-1:0]       nx_rem_x, nx_rem_y;
    logic                              out_free;
    logic                              load_out;
    logic                              found;
    tcent_pkg::t_result                res;

    // One restoring step per cycle for both quotients
    assign dvs      = {1'b0, r_cnt};
    assign sh_x     = {r_rem_x, r_dvd_x[tcent_pkg::SUM_W-1]};
    assign sh_y     = {r_rem_y, r_dvd_y[tcent_pkg::SUM_W-1]};
    assign ge_x     = (sh_x >= dvs);
    assign ge_y     = (sh_y >= dvs);
    assign nx_rem_x = ge_x ? sh_x - dvs : sh_x;
    assign nx_rem_y = ge_y ? sh_y - dvs : sh_y;

    // Output register frees up when empty or taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_status.empty;
    assign load_out = (r_state == S_DONE) && out_free;

    // Build the result: quotient minus one, zero when nothing was found
    assign found                = (r_cnt != '0);
    assign res.found            = found;
    assign res.foreground_count = r_cnt;
    assign res.centroid_x       = found ? r_q_x - tcent_pkg::CENT_W'(1) : '0;
    assign res.centroid_y       = found ? r_q_y - tcent_pkg::CENT_W'(1) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == tcent_pkg::STEP_W'(tcent_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt   <= i_pop_data.count;
            r_dvd_x <= i_pop_data.col_sum;
            r_dvd_y <= i_pop_data.row_sum;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_step  <= '0;
        end else if (r_state == S_DIV) begin
            r_dvd_x <= {r_dvd_x[tcent_pkg::SUM_W-2:0], 1'b0};
            r_dvd_y <= {r_dvd_y[tcent_pkg::SUM_W-2:0], 1'b0};
            r_rem_x <= nx_rem_x[tcent_pkg::COUNT_W-1:0];
            r_rem_y <= nx_rem_y[tcent_pkg::COUNT_W-1:0];
            r_q_x   <= {r_q_x[tcent_pkg::CENT_W-2:0], ge_x};
            r_q_y   <= {r_q_y[tcent_pkg::CENT_W-2:0], ge_y};
            r_step  <= r_step + tcent_pkg::STEP_W'(1);
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/threshold_centroid_tracker_top.sv =====
`timescale 1ns / 1ps

// Thresholded blob centroid over a raster RGB pixel stream. The block takes one
// pixel word per clock; its input stalls only while the two-entry frame queue is
// full. Each frame's last pixel hands the frame totals to the queue, and a back end
// then divides both coordinate sums by the foreground count with two restoring
// dividers that produce one quotient bit per cycle; the back end pops the totals,
// runs 31 division steps and loads the output register. The front end takes the
// next frame while the back end divides, so pixels flow at a full pixel per clock
// until the queue fills. Configuration writes are taken at any time but belong
// between frames.
module threshold_centroid_tracker_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tcent_pkg::t_pixel                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tcent_pkg::t_result                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tcent_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcent_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tcent_pkg::t_q_status  q_status;
    tcent_pkg::t_frame_sum push_data;
    tcent_pkg::t_frame_sum pop_data;
    logic                  push;
    logic                  pop;

    // Classify and accumulate pixels
    tcent_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Buffer finished frames
    tcent_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // Divide and emit centroids
    tcent_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/tcent_checker.sv =====
`timescale 1ns / 1ps

module tcent_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcent_pkg::t_result o_out_data
);

    // Reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // Found flag agrees with the count
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.found == (o_out_data.foreground_count != '0)))
        else $error("found flag disagrees with foreground count");

    // Empty frame reports a zero centroid
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found
            |-> (o_out_data.centroid_x == '0) && (o_out_data.centroid_y == '0))
        else $error("nonzero centroid for empty frame");

endmodule

bind threshold_centroid_tracker_top tcent_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
